// ===== design/ahfp_pkg.sv =====
// ----------------------------------------------------------------------------
// ahfp_pkg: shared definitions for the hex line frame parser
// Holds the line store geometry, the line formats, the result kinds, the
// sequencer states and the hex digit decoder.
// ----------------------------------------------------------------------------
package ahfp_pkg;

  // Line store geometry.
  localparam int unsigned LINE_MAX = 64;
  localparam int unsigned ADDR_W   = $clog2(LINE_MAX);
  localparam int unsigned CNT_W    = $clog2(LINE_MAX + 1);

  // Field widths.
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned IDX_W  = 4;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned SRC_W  = 8;
  localparam int unsigned NIB_W  = 4;
  localparam int unsigned POS_W  = 5;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_LONG   = KIND_W'(0);
  localparam logic [KIND_W-1:0] KIND_SHORT  = KIND_W'(1);
  localparam logic [KIND_W-1:0] KIND_FREQ   = KIND_W'(2);
  localparam logic [KIND_W-1:0] KIND_REJECT = KIND_W'(3);

  // Line lengths in characters.
  localparam logic [CNT_W-1:0] LEN_STAMP_SHORT = CNT_W'(28);
  localparam logic [CNT_W-1:0] LEN_STAMP_LONG  = CNT_W'(42);
  localparam logic [CNT_W-1:0] LEN_LONG        = CNT_W'(30);
  localparam logic [CNT_W-1:0] LEN_SHORT       = CNT_W'(16);
  localparam logic [CNT_W-1:0] LEN_FREQ        = CNT_W'(10);
  localparam logic [CNT_W-1:0] STAMP_CUT       = CNT_W'(12);

  // A stamped line drops 13 leading characters and gains a star in front,
  // so view position p lives at store index p + 12.
  localparam logic [ADDR_W-1:0] STAMP_OFFSET = ADDR_W'(12);

  // Character positions.
  localparam logic [POS_W-1:0] TS_FIRST  = POS_W'(5);
  localparam logic [POS_W-1:0] TS_LAST   = POS_W'(12);
  localparam logic [POS_W-1:0] FREQ_LAST = POS_W'(8);
  localparam logic [POS_W-1:0] POS_LEAD  = POS_W'(0);
  localparam logic [POS_W-1:0] POS_FIRST = POS_W'(1);

  // Frame byte counts.
  localparam logic [IDX_W-1:0] BYTES_LONG  = IDX_W'(14);
  localparam logic [IDX_W-1:0] BYTES_SHORT = IDX_W'(7);
  localparam logic [IDX_W-1:0] BYTES_FREQ  = IDX_W'(4);

  // Lead characters.
  localparam logic [CHAR_W-1:0] CHAR_STAR = 8'h2A;
  localparam logic [CHAR_W-1:0] CHAR_HASH = 8'h23;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_TS,
    ST_LEAD,
    ST_FREQ,
    ST_HI,
    ST_LO,
    ST_EMIT
  } prs_state_e;

  typedef struct packed {
    logic             ok;
    logic [NIB_W-1:0] val;
  } hex_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [CHAR_W-1:0] data;
  } ram_wr_t;

  // Decodes one ASCII hex digit of either case.
  function automatic hex_t hex_decode(input logic [CHAR_W-1:0] c);
    hex_t r;
    r.ok  = 1'b1;
    r.val = '0;
    if (c inside {[8'h30:8'h39]}) begin
      r.val = NIB_W'(c - 8'h30);
    end else if (c inside {[8'h61:8'h66]}) begin
      r.val = NIB_W'(c - 8'h57);
    end else if (c inside {[8'h41:8'h46]}) begin
      r.val = NIB_W'(c - 8'h37);
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

// ===== design/ahfp_if.sv =====
// ----------------------------------------------------------------------------
// ahfp_if: channel interfaces of the hex line frame parser
// Character input, result output and source number write channels, each
// with valid, ready and its payload.
// ----------------------------------------------------------------------------
interface ahfp_in_if import ahfp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              end_of_line;

  modport source (output valid, char_code, end_of_line, input ready);
  modport sink   (input valid, char_code, end_of_line, output ready);
endinterface

interface ahfp_out_if import ahfp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [CHAR_W-1:0] data_byte;
  logic [IDX_W-1:0]  byte_index;
  logic              byte_valid;
  logic [IDX_W-1:0]  frame_length;
  logic [WORD_W-1:0] timestamp;
  logic [WORD_W-1:0] frequency_hz;
  logic              frequency_valid;
  logic [SRC_W-1:0]  source_tag;
  logic [WORD_W-1:0] total_chars;
  logic              last;

  modport source (output valid, kind, data_byte, byte_index, byte_valid, frame_length,
                  timestamp, frequency_hz, frequency_valid, source_tag, total_chars,
                  last, input ready);
  modport sink   (input valid, kind, data_byte, byte_index, byte_valid, frame_length,
                  timestamp, frequency_hz, frequency_valid, source_tag, total_chars,
                  last, output ready);
endinterface

interface ahfp_cfg_if import ahfp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SRC_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== design/ahfp_line_ram.sv =====
// ----------------------------------------------------------------------------
// ahfp_line_ram: line character store
// One write port and one read port; read data is registered, so it appears
// in the cycle after the address.
// ----------------------------------------------------------------------------
module ahfp_line_ram import ahfp_pkg::*; (
  input  logic              clk_i,
  input  ram_wr_t           wr_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [CHAR_W-1:0] rdata_o
);

  logic [CHAR_W-1:0] mem [LINE_MAX];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== design/adsb_hex_line_frame_parser.sv =====
// ----------------------------------------------------------------------------
// adsb_hex_line_frame_parser: receiver text line to frame byte parser
// Stores one text line character by character and, at its end, walks the
// stored line to decode the timestamp, frequency and frame bytes.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake     Payload
// cfg_i     in   valid/ready   data: source number attached to frequency reports
// in_i      in   valid/ready   char_code, end_of_line
// out_o     out  valid/ready   one frame byte per item, or one item for a rejected line
//
// While the parser collects a line, in_i.ready is high and a character is
// taken whenever in_i.valid is set. The item carrying end_of_line starts the
// decode, during which in_i.ready is low. The decode reads the line store
// through its single read port, each character by an address step and then a
// registered data step, and loads one result item per frame byte.
// A stall on out_o holds the current result and pauses the decode.
// Reset clears the line count, the character total and the source number; the
// line store itself needs no clearing, as only characters of the current line
// are read.
// ----------------------------------------------------------------------------
module adsb_hex_line_frame_parser import ahfp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  ahfp_cfg_if.sink    cfg_i,
  ahfp_in_if.sink     in_i,
  ahfp_out_if.source  out_o
);

  // Sequencer and line bookkeeping.
  prs_state_e        state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              over_q, over_d;
  logic [WORD_W-1:0] total_q, total_d;
  logic [SRC_W-1:0]  src_q, src_d;
  logic              phase_q, phase_d;

  // Decode state of the line under work.
  logic              stamped_q, stamped_d;
  logic [KIND_W-1:0] kind_q, kind_d;
  logic [IDX_W-1:0]  nbytes_q, nbytes_d;
  logic [WORD_W-1:0] ts_q, ts_d;
  logic [WORD_W-1:0] freq_q, freq_d;
  logic              fvalid_q, fvalid_d;
  logic              ok_q, ok_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [IDX_W-1:0]  byte_idx_q, byte_idx_d;
  logic [NIB_W-1:0]  hi_q, hi_d;

  // Output register.
  logic              out_valid_q;
  logic [KIND_W-1:0] out_kind_q;
  logic [CHAR_W-1:0] out_byte_q;
  logic [IDX_W-1:0]  out_idx_q;
  logic              out_bvalid_q;
  logic [IDX_W-1:0]  out_len_q;
  logic [WORD_W-1:0] out_ts_q;
  logic [WORD_W-1:0] out_freq_q;
  logic              out_fvalid_q;
  logic [SRC_W-1:0]  out_src_q;
  logic [WORD_W-1:0] out_total_q;
  logic              out_last_q;

  // Line store access.
  ram_wr_t           ram_wr;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CHAR_W-1:0] ram_rdata;
  hex_t              rd_hex;

  // Handshake and classification.
  logic              in_ready;
  logic              in_fire;
  logic              out_fire;
  logic              room;
  logic [CNT_W-1:0]  count_inc;
  logic              stamped_c;
  logic [CNT_W-1:0]  eff_c;
  logic [KIND_W-1:0] kind_c;
  logic              lead_ok;
  logic              last_byte;

  // Result loading.
  logic              load_byte;
  logic              load_reject;
  logic [CHAR_W-1:0] new_byte;
  logic              new_bvalid;

  ahfp_line_ram u_ram (
    .clk_i   (clk_i),
    .wr_i    (ram_wr),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // The input side only takes characters while no line is being decoded, so a
  // store write never meets a read of the same line.
  assign in_ready    = (state_q == ST_IDLE);
  assign in_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;
  assign in_fire     = in_i.valid && in_ready;
  assign out_fire    = out_valid_q && out_o.ready;

  // Characters past the store depth are dropped and mark the line as overlong.
  assign room      = (count_q < CNT_W'(LINE_MAX));
  assign count_inc = count_q + CNT_W'(room);

  // A line of 28 or 42 characters carries a timestamp and is cut by 12.
  assign stamped_c = !over_q && ((count_q == LEN_STAMP_SHORT) || (count_q == LEN_STAMP_LONG));
  assign eff_c     = stamped_c ? (count_q - STAMP_CUT) : count_q;

  always_comb begin
    kind_c = KIND_REJECT;
    if (!over_q) begin
      if (eff_c == LEN_LONG) begin
        kind_c = KIND_LONG;
      end else if (eff_c == LEN_SHORT) begin
        kind_c = KIND_SHORT;
      end else if (eff_c == LEN_FREQ) begin
        kind_c = KIND_FREQ;
      end
    end
  end

  // The timestamp walk uses raw store indexes; every other walk goes through
  // the view of the line, which is shifted on stamped lines.
  assign ram_raddr = (stamped_q && (state_q != ST_TS)) ?
                     (ADDR_W'(pos_q) + STAMP_OFFSET) : ADDR_W'(pos_q);

  assign rd_hex    = hex_decode(ram_rdata);
  assign lead_ok   = (ram_rdata == ((kind_q == KIND_FREQ) ? CHAR_HASH : CHAR_STAR));
  assign last_byte = (byte_idx_q == (nbytes_q - IDX_W'(1)));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && in_i.end_of_line) begin
          state_d = ST_CLASSIFY;
        end
      end
      ST_CLASSIFY: begin
        if (kind_c == KIND_REJECT) begin
          state_d = ST_EMIT;
        end else if (stamped_c) begin
          state_d = ST_TS;
        end else begin
          state_d = ST_LEAD;
        end
      end
      ST_TS: begin
        if (phase_q && (!rd_hex.ok || (pos_q == TS_LAST))) begin
          state_d = ST_HI;
        end
      end
      ST_LEAD: begin
        if (phase_q) begin
          state_d = ((kind_q == KIND_FREQ) && lead_ok) ? ST_FREQ : ST_HI;
        end
      end
      ST_FREQ: begin
        if (phase_q && (!rd_hex.ok || (pos_q == FREQ_LAST))) begin
          state_d = ST_HI;
        end
      end
      ST_HI: begin
        if (!ok_q) begin
          state_d = ST_EMIT;
        end else if (phase_q) begin
          state_d = rd_hex.ok ? ST_LO : ST_EMIT;
        end
      end
      ST_LO: begin
        if (phase_q) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_fire) begin
          state_d = out_last_q ? ST_IDLE : ST_HI;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Datapath, store accesses and result loading.
  always_comb begin
    count_d     = count_q;
    over_d      = over_q;
    total_d     = total_q;
    src_d       = src_q;
    phase_d     = phase_q;
    stamped_d   = stamped_q;
    kind_d      = kind_q;
    nbytes_d    = nbytes_q;
    ts_d        = ts_q;
    freq_d      = freq_q;
    fvalid_d    = fvalid_q;
    ok_d        = ok_q;
    pos_d       = pos_q;
    byte_idx_d  = byte_idx_q;
    hi_d        = hi_q;
    ram_wr      = '0;
    load_byte   = 1'b0;
    load_reject = 1'b0;
    new_byte    = '0;
    new_bvalid  = 1'b0;

    if (cfg_i.valid) begin
      src_d = cfg_i.data;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (room) begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = count_q[ADDR_W-1:0];
            ram_wr.data = in_i.char_code;
          end else begin
            over_d = 1'b1;
          end
          count_d = count_inc;
          if (in_i.end_of_line) begin
            total_d = total_q + WORD_W'(count_inc);
          end
        end
      end
      ST_CLASSIFY: begin
        // The store contents stay put; only the count and the overlong flag restart for the next line.
        stamped_d  = stamped_c;
        kind_d     = kind_c;
        ts_d       = '0;
        freq_d     = '0;
        fvalid_d   = 1'b0;
        ok_d       = 1'b1;
        byte_idx_d = '0;
        phase_d    = 1'b0;
        pos_d      = stamped_c ? TS_FIRST : POS_LEAD;
        count_d    = '0;
        over_d     = 1'b0;
        case (kind_c)
          KIND_LONG:  nbytes_d = BYTES_LONG;
          KIND_SHORT: nbytes_d = BYTES_SHORT;
          KIND_FREQ:  nbytes_d = BYTES_FREQ;
          default:    nbytes_d = '0;
        endcase
        load_reject = (kind_c == KIND_REJECT);
      end
      ST_TS: begin
        phase_d = !phase_q;
        if (phase_q) begin
          pos_d = pos_q + POS_W'(1);
          if (rd_hex.ok) begin
            ts_d = {ts_q[WORD_W-NIB_W-1:0], rd_hex.val};
          end
          if (!rd_hex.ok || (pos_q == TS_LAST)) begin
            pos_d = POS_FIRST;
          end
        end
      end
      ST_LEAD: begin
        phase_d = !phase_q;
        if (phase_q) begin
          ok_d  = lead_ok;
          pos_d = POS_FIRST;
        end
      end
      ST_FREQ: begin
        phase_d = !phase_q;
        if (phase_q) begin
          pos_d = pos_q + POS_W'(1);
          if (rd_hex.ok) begin
            freq_d   = {freq_q[WORD_W-NIB_W-1:0], rd_hex.val};
            fvalid_d = 1'b1;
          end
          if (!rd_hex.ok || (pos_q == FREQ_LAST)) begin
            pos_d = POS_FIRST;
          end
        end
      end
      ST_HI: begin
        if (!ok_q) begin
          // Once a digit has failed, the remaining bytes go out invalid unread.
          load_byte = 1'b1;
        end else begin
          phase_d = !phase_q;
          if (phase_q) begin
            if (rd_hex.ok) begin
              hi_d  = rd_hex.val;
              pos_d = pos_q + POS_W'(1);
            end else begin
              ok_d      = 1'b0;
              load_byte = 1'b1;
            end
          end
        end
      end
      ST_LO: begin
        phase_d = !phase_q;
        if (phase_q) begin
          pos_d      = pos_q + POS_W'(1);
          load_byte  = 1'b1;
          new_bvalid = 1'b1;
          if (rd_hex.ok) begin
            new_byte = {hi_q, rd_hex.val};
          end else begin
            // A bad low digit leaves the high digit alone as the byte value.
            new_byte = CHAR_W'(hi_q);
            ok_d     = 1'b0;
          end
        end
      end
      ST_EMIT: begin
        if (out_fire && !out_last_q) begin
          byte_idx_d = byte_idx_q + IDX_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      over_q      <= 1'b0;
      total_q     <= '0;
      src_q       <= '0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      over_q  <= over_d;
      total_q <= total_d;
      src_q   <= src_d;
      phase_q <= phase_d;
      if (load_byte || load_reject) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    stamped_q  <= stamped_d;
    kind_q     <= kind_d;
    nbytes_q   <= nbytes_d;
    ts_q       <= ts_d;
    freq_q     <= freq_d;
    fvalid_q   <= fvalid_d;
    ok_q       <= ok_d;
    pos_q      <= pos_d;
    byte_idx_q <= byte_idx_d;
    hi_q       <= hi_d;
  end

  // The result register is only loaded while it is empty, since loads happen
  // outside the emit state.
  always_ff @(posedge clk_i) begin
    if (load_reject) begin
      out_kind_q   <= KIND_REJECT;
      out_byte_q   <= '0;
      out_idx_q    <= '0;
      out_bvalid_q <= 1'b0;
      out_len_q    <= '0;
      out_ts_q     <= '0;
      out_freq_q   <= '0;
      out_fvalid_q <= 1'b0;
      out_src_q    <= '0;
      out_total_q  <= total_q;
      out_last_q   <= 1'b1;
    end else if (load_byte) begin
      out_kind_q   <= kind_q;
      out_byte_q   <= new_byte;
      out_idx_q    <= byte_idx_q;
      out_bvalid_q <= new_bvalid;
      out_len_q    <= nbytes_q;
      out_ts_q     <= ts_q;
      out_freq_q   <= fvalid_q ? freq_q : '0;
      out_fvalid_q <= fvalid_q;
      out_src_q    <= (kind_q == KIND_FREQ) ? src_q : '0;
      out_total_q  <= total_q;
      out_last_q   <= last_byte;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.kind            = out_kind_q;
  assign out_o.data_byte       = out_byte_q;
  assign out_o.byte_index      = out_idx_q;
  assign out_o.byte_valid      = out_bvalid_q;
  assign out_o.frame_length    = out_len_q;
  assign out_o.timestamp       = out_ts_q;
  assign out_o.frequency_hz    = out_freq_q;
  assign out_o.frequency_valid = out_fvalid_q;
  assign out_o.source_tag      = out_src_q;
  assign out_o.total_chars     = out_total_q;
  assign out_o.last            = out_last_q;

endmodule

// ===== design/ahfp_checker.sv =====
// ----------------------------------------------------------------------------
// ahfp_checker: port level checks for the hex line frame parser
// Watches the top level ports and is attached by the bind below.
// ----------------------------------------------------------------------------
module ahfp_checker import ahfp_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [KIND_W-1:0] out_kind_i,
  input logic [CHAR_W-1:0] out_data_byte_i,
  input logic [IDX_W-1:0]  out_byte_index_i,
  input logic              out_byte_valid_i,
  input logic [IDX_W-1:0]  out_frame_length_i,
  input logic              out_last_i
);

  // A pending result stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn before it was taken");

  // Characters are only taken while no result of a line is pending.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i |-> !out_valid_i)
    else $error("input ready while a result is pending");

  // A rejected line gives exactly one empty, final result.
  a_reject_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_kind_i == KIND_REJECT) |->
      out_last_i && (out_frame_length_i == '0) && !out_byte_valid_i)
    else $error("malformed rejected-line result");

  // Frame bytes stay inside the frame, and the last flag sits on the last one.
  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_kind_i != KIND_REJECT) |->
      (out_byte_index_i < out_frame_length_i) &&
      (out_last_i == (out_byte_index_i == (out_frame_length_i - IDX_W'(1)))))
    else $error("byte index or last flag out of place");

  // A byte that was not decoded reads as zero.
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_byte_valid_i |-> (out_data_byte_i == '0))
    else $error("invalid byte carries data");

endmodule

bind adsb_hex_line_frame_parser ahfp_checker u_ahfp_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_ready_i         (in_i.ready),
  .out_valid_i        (out_o.valid),
  .out_ready_i        (out_o.ready),
  .out_kind_i         (out_o.kind),
  .out_data_byte_i    (out_o.data_byte),
  .out_byte_index_i   (out_o.byte_index),
  .out_byte_valid_i   (out_o.byte_valid),
  .out_frame_length_i (out_o.frame_length),
  .out_last_i         (out_o.last)
);
